/* src/bsa_pkg.sv */
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants for the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int NUM_SLOTS_DEF = 64;
    localparam int ADDR_W        = 64;
    localparam int SHIFT_W       = 5;
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_SHIFT   = 4'd1;

    localparam logic [SHIFT_W-1:0] SLOT_SHIFT_RESET = 5'd16;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR = 2'd2;

    localparam logic CMD_FREE  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   slot_address;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic set;   // mark addressed slot used and drop the scan token there
        logic clr;   // mark addressed slot free
        logic scan;  // token moves one cell up
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FREE,
        ST_SCAN,
        ST_POST
    } state_t;

endpackage

/* src/bitmap_slot_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Fixed-size slot allocator over a used bitmap with a lowest-free hint.
// ----------------------------------------------------------------------------
// One request is worked on at a time. A free passes through the address
// subtract, then the shift and range check, then the output load. An allocate
// scans, before the output load, from the allocated slot to the next free one,
// or to the last slot when none above is free: the scan token moves one cell
// of the slot chain per cycle to find the new hint. An allocate on a full
// region skips the scan. s_ready returns in the cycle after the output load,
// so the next request is taken only after the previous result is loaded. The
// bitmap is held in the cells and cleared by reset. The next request is taken
// while a result still waits at m_.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator #(
    parameter int NUM_SLOTS = bsa_pkg::NUM_SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  bsa_pkg::req_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output bsa_pkg::rsp_t                   m_data,
    input  logic                            cfg_wr_en,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bsa_pkg::ADDR_W-1:0]      cfg_wr_data
);

    localparam int IDX_W  = $clog2(NUM_SLOTS);
    localparam int HINT_W = $clog2(NUM_SLOTS + 1);
    localparam int AW     = bsa_pkg::ADDR_W;

    bsa_pkg::state_t state_reg, state_next;

    logic [AW-1:0]                  base_reg;
    logic [bsa_pkg::SHIFT_W-1:0]    shift_reg;
    logic [HINT_W-1:0]              hint_reg, hint_next;
    logic [IDX_W-1:0]               scan_idx_reg, scan_idx_next;
    logic                           cmd_reg;
    logic [AW-1:0]                  addr_reg;
    logic [AW-1:0]                  diff_reg, diff_next;
    logic                           below_reg, below_next;
    logic [AW-1:0]                  res_addr_reg, res_addr_next;
    logic [bsa_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                           m_valid_reg, m_valid_next;
    bsa_pkg::rsp_t                  m_data_reg, m_data_next;

    bsa_pkg::cell_ctrl_t            ctrl;
    logic [IDX_W-1:0]               cell_idx;
    logic                           found;

    logic                           full;
    logic                           out_free;
    logic                           scan_end;
    logic [AW-1:0]                  idx_wide;
    logic                           bad_addr;

    assign full     = (hint_reg == HINT_W'(NUM_SLOTS));
    assign out_free = !m_valid_reg || m_ready;
    assign scan_end = (scan_idx_reg == IDX_W'(NUM_SLOTS - 1));
    assign idx_wide = diff_reg >> shift_reg;
    assign bad_addr = below_reg || (idx_wide >= AW'(NUM_SLOTS));

    assign s_ready  = (state_reg == bsa_pkg::ST_IDLE);

    bsa_cell_row #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_row (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .idx     (cell_idx),
        .found   (found)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bsa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = bsa_pkg::ST_EXEC;
                end
            end
            bsa_pkg::ST_EXEC: begin
                if (cmd_reg == bsa_pkg::CMD_FREE) begin
                    state_next = bsa_pkg::ST_FREE;
                end else if (full) begin
                    state_next = bsa_pkg::ST_POST;
                end else begin
                    state_next = bsa_pkg::ST_SCAN;
                end
            end
            bsa_pkg::ST_FREE: begin
                state_next = bsa_pkg::ST_POST;
            end
            bsa_pkg::ST_SCAN: begin
                if (found || scan_end) begin
                    state_next = bsa_pkg::ST_POST;
                end
            end
            bsa_pkg::ST_POST: begin
                if (out_free) begin
                    state_next = bsa_pkg::ST_IDLE;
                end
            end
            default: state_next = bsa_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        ctrl            = '0;
        cell_idx        = hint_reg[IDX_W-1:0];
        hint_next       = hint_reg;
        scan_idx_next   = scan_idx_reg;
        diff_next       = diff_reg;
        below_next      = below_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        unique case (state_reg)
            bsa_pkg::ST_IDLE: begin
            end
            bsa_pkg::ST_EXEC: begin
                diff_next       = addr_reg - base_reg;
                below_next      = (addr_reg < base_reg);
                res_addr_next   = '0;
                res_status_next = bsa_pkg::STATUS_OK;
                if (cmd_reg == bsa_pkg::CMD_ALLOC) begin
                    if (full) begin
                        res_status_next = bsa_pkg::STATUS_FULL;
                    end else begin
                        ctrl.set      = 1'b1;
                        scan_idx_next = hint_reg[IDX_W-1:0];
                        res_addr_next = base_reg + (AW'(hint_reg) << shift_reg);
                    end
                end
            end
            bsa_pkg::ST_FREE: begin
                cell_idx = idx_wide[IDX_W-1:0];
                if (bad_addr) begin
                    res_status_next = bsa_pkg::STATUS_BAD_ADDR;
                end else begin
                    ctrl.clr = 1'b1;
                    if (HINT_W'(idx_wide[IDX_W-1:0]) < hint_reg) begin
                        hint_next = HINT_W'(idx_wide[IDX_W-1:0]);
                    end
                end
            end
            bsa_pkg::ST_SCAN: begin
                if (found) begin
                    hint_next = HINT_W'(scan_idx_reg);
                end else if (scan_end) begin
                    hint_next = HINT_W'(NUM_SLOTS);
                end else begin
                    ctrl.scan     = 1'b1;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            bsa_pkg::ST_POST: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.slot_address = res_addr_reg;
                    m_data_next.status       = res_status_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bsa_pkg::ST_IDLE;
            hint_reg     <= '0;
            m_valid_reg  <= 1'b0;
            base_reg     <= '0;
            shift_reg    <= bsa_pkg::SLOT_SHIFT_RESET;
        end else begin
            state_reg    <= state_next;
            hint_reg     <= hint_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    bsa_pkg::REG_BASE_ADDRESS: base_reg  <= cfg_wr_data;
                    bsa_pkg::REG_SLOT_SHIFT:   shift_reg <= cfg_wr_data[bsa_pkg::SHIFT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg  <= s_data.command;
            addr_reg <= s_data.free_address;
        end
        scan_idx_reg   <= scan_idx_next;
        diff_reg       <= diff_next;
        below_reg      <= below_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* src/bsa_cell.sv */
// ----------------------------------------------------------------------------
// bsa_cell
// One slot: its used bit and a scan token passed on to the next cell.
// ----------------------------------------------------------------------------
module bsa_cell #(
    parameter int IDX_W      = 6,
    parameter int CELL_INDEX = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bsa_pkg::cell_ctrl_t ctrl,
    input  logic [IDX_W-1:0]    idx,
    input  logic                token_in,
    output logic                token_out,
    output logic                hit_free
);

    logic used_reg, used_next;
    logic token_reg, token_next;
    logic sel;

    assign sel = (idx == IDX_W'(CELL_INDEX));

    always_comb begin
        used_next = used_reg;
        if (ctrl.set && sel) begin
            used_next = 1'b1;
        end else if (ctrl.clr && sel) begin
            used_next = 1'b0;
        end
    end

    always_comb begin
        if (ctrl.set) begin
            token_next = sel;
        end else if (ctrl.scan) begin
            token_next = token_in;
        end else begin
            token_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= 1'b0;
            token_reg <= 1'b0;
        end else begin
            used_reg  <= used_next;
            token_reg <= token_next;
        end
    end

    assign token_out = token_reg;
    assign hit_free  = token_reg & ~used_reg;

endmodule

/* src/bsa_cell_row.sv */
// ----------------------------------------------------------------------------
// bsa_cell_row
// Chain of slot cells; reports when the scan token sits on a free slot.
// ----------------------------------------------------------------------------
module bsa_cell_row #(
    parameter int NUM_SLOTS = bsa_pkg::NUM_SLOTS_DEF,
    parameter int IDX_W     = $clog2(NUM_SLOTS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bsa_pkg::cell_ctrl_t ctrl,
    input  logic [IDX_W-1:0]    idx,
    output logic                found
);

    logic [NUM_SLOTS:0]   token;
    logic [NUM_SLOTS-1:0] hit;

    assign token[0] = 1'b0;

    for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
        bsa_cell #(
            .IDX_W      (IDX_W),
            .CELL_INDEX (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .idx       (idx),
            .token_in  (token[i]),
            .token_out (token[i+1]),
            .hit_free  (hit[i])
        );
    end

    assign found = |hit;

endmodule

/* src/bsa_checker.sv */
// ----------------------------------------------------------------------------
// bsa_checker
// Port-level checks on the slot allocator request and result channels.
// ----------------------------------------------------------------------------
module bsa_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input bsa_pkg::req_t                   s_data,
    input logic                            m_valid,
    input logic                            m_ready,
    input bsa_pkg::rsp_t                   m_data,
    input logic                            cfg_wr_en
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("request changed while waiting");

    a_err_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != bsa_pkg::STATUS_OK |->
            m_data.slot_address == '0 && m_data.status <= bsa_pkg::STATUS_BAD_ADDR)
        else $error("bad error result");

    a_cfg_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |-> s_ready && !s_valid && !m_valid)
        else $error("register write while busy");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_data      (s_data),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_data      (m_data),
    .cfg_wr_en   (cfg_wr_en)
);

/* tb/sv/bitmap_slot_allocator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_tb
// Self-checking bench for the bitmap slot allocator. A directed table covers
// reset state, full region, wrap-around, misaligned and out-of-range frees and
// the shift extremes; random phases then re-program base and shift and mix
// allocate bursts with frees, all checked against an in-bench allocator model.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_tb;

    localparam int NUM_SLOTS = bsa_pkg::NUM_SLOTS_DEF;
    localparam int IDX_W     = $clog2(NUM_SLOTS);
    localparam int ADDR_W    = bsa_pkg::ADDR_W;
    localparam int CFG_IDX_W = bsa_pkg::CFG_IDX_W;
    localparam int SHIFT_W   = bsa_pkg::SHIFT_W;
    localparam int STATUS_W  = bsa_pkg::STATUS_W;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic                    cmd;
        logic [ADDR_W-1:0]       value;
        int                      reps;
        bit                      typed;
        bsa_pkg::rsp_t           want;
    } dir_row_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    bsa_pkg::req_t        s_data      = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    bsa_pkg::rsp_t        m_data;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [ADDR_W-1:0]    cfg_wr_data = '0;

    // allocator model state
    logic [ADDR_W-1:0]    region_base;
    logic [SHIFT_W-1:0]   slot_log2;
    bit [NUM_SLOTS-1:0]   slot_map;
    int unsigned          next_free_slot;

    bsa_pkg::rsp_t        expected_rsp_q[$];
    bsa_pkg::rsp_t        want_rsp;
    dir_row_t             dir_rows[$];
    int                   fail_count = 0;
    bit                   idle_on    = 1'b1;

    bitmap_slot_allocator #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= idle_on ? ($urandom_range(99) >= 30) : 1'b1;
    end

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bsa_pkg::rsp_t allocator_step(bsa_pkg::req_t r);
        bsa_pkg::rsp_t     res;
        logic [ADDR_W-1:0] idx;
        int unsigned       k;
        res.slot_address = '0;
        res.status       = bsa_pkg::STATUS_OK;
        if (r.command == bsa_pkg::CMD_ALLOC) begin
            if (next_free_slot >= NUM_SLOTS) begin
                res.status = bsa_pkg::STATUS_FULL;
            end else begin
                slot_map[next_free_slot[IDX_W-1:0]] = 1'b1;
                res.slot_address = region_base + (64'(next_free_slot) << slot_log2);
                for (k = 0; k < NUM_SLOTS && slot_map[k[IDX_W-1:0]]; k++);
                next_free_slot = k;
            end
        end else if (r.free_address < region_base) begin
            res.status = bsa_pkg::STATUS_BAD_ADDR;
        end else begin
            idx = (r.free_address - region_base) >> slot_log2;
            if (idx >= NUM_SLOTS) begin
                res.status = bsa_pkg::STATUS_BAD_ADDR;
            end else begin
                slot_map[idx[IDX_W-1:0]] = 1'b0;
                if (idx < next_free_slot)
                    next_free_slot = 32'(idx);
            end
        end
        return res;
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
        dir_row_t row;
        row = '{ROW_CFG, idx, bsa_pkg::CMD_FREE, data, 1, 1'b0, '0};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_req(logic cmd, logic [ADDR_W-1:0] addr, int reps);
        dir_row_t row;
        row = '{ROW_REQ, bsa_pkg::REG_BASE_ADDRESS, cmd, addr, reps, 1'b0, '0};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_chk(logic cmd, logic [ADDR_W-1:0] addr,
                                    logic [ADDR_W-1:0] exp_addr,
                                    logic [STATUS_W-1:0] exp_status);
        dir_row_t row;
        row = '{ROW_REQ, bsa_pkg::REG_BASE_ADDRESS, cmd, addr, 1, 1'b1,
                '{exp_addr, exp_status}};
        dir_rows.push_back(row);
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        if (idx == bsa_pkg::REG_BASE_ADDRESS)
            region_base = data;
        else if (idx == bsa_pkg::REG_SLOT_SHIFT)
            slot_log2 = data[SHIFT_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_req(bsa_pkg::req_t r, bit typed, bsa_pkg::rsp_t want);
        int            gap;
        bsa_pkg::rsp_t got;
        @(negedge aclk);
        if (idle_on && $urandom_range(99) < 30) begin
            gap = $urandom_range(1, ($urandom_range(3) == 0) ? 70 : 4);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= r;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        got = allocator_step(r);
        expected_rsp_q.push_back(typed ? want : got);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_rsp_q.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected response: addr %h status %0d",
                             m_data.slot_address, m_data.status);
                fail_count++;
            end else begin
                want_rsp = expected_rsp_q.pop_front();
                if (m_data.slot_address !== want_rsp.slot_address ||
                    m_data.status !== want_rsp.status) begin
                    if (fail_count < 10)
                        $display("mismatch: addr exp %h got %h, status exp %0d got %0d",
                                 want_rsp.slot_address, m_data.slot_address,
                                 want_rsp.status, m_data.status);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stim
        bsa_pkg::req_t     r;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] data;
        int                alloc_pct;
        int                pick;
        int                n;
        int                ph;

        region_base    = '0;
        slot_log2      = bsa_pkg::SLOT_SHIFT_RESET;
        slot_map       = '0;
        next_free_slot = 0;

        // reset defaults: base 0, 64 KiB slots
        add_chk(bsa_pkg::CMD_ALLOC, 64'h0,       64'h0,       bsa_pkg::STATUS_OK);
        add_chk(bsa_pkg::CMD_ALLOC, ~64'h0,      64'h1_0000,  bsa_pkg::STATUS_OK);
        add_chk(bsa_pkg::CMD_FREE,  64'h1_1234,  64'h0,       bsa_pkg::STATUS_OK);
        add_chk(bsa_pkg::CMD_FREE,  64'h0,       64'h0,       bsa_pkg::STATUS_OK);
        add_chk(bsa_pkg::CMD_FREE,  64'h0,       64'h0,       bsa_pkg::STATUS_OK);
        add_chk(bsa_pkg::CMD_FREE,  64'h40_0000, 64'h0,       bsa_pkg::STATUS_BAD_ADDR);
        add_chk(bsa_pkg::CMD_FREE,  ~64'h0,      64'h0,       bsa_pkg::STATUS_BAD_ADDR);
        add_req(bsa_pkg::CMD_ALLOC, 64'h5A5A_5A5A_5A5A_5A5A, NUM_SLOTS);
        add_chk(bsa_pkg::CMD_ALLOC, 64'h0,       64'h0,       bsa_pkg::STATUS_FULL);
        add_chk(bsa_pkg::CMD_FREE,  64'h3F_FFFF, 64'h0,       bsa_pkg::STATUS_OK);
        add_chk(bsa_pkg::CMD_ALLOC, 64'h0,       64'h3F_0000, bsa_pkg::STATUS_OK);
        // byte slots, then base at the top so slot 1 wraps to zero
        add_cfg(bsa_pkg::REG_SLOT_SHIFT, 64'h0);
        add_chk(bsa_pkg::CMD_FREE,  64'h1,       64'h0,       bsa_pkg::STATUS_OK);
        add_chk(bsa_pkg::CMD_FREE,  64'h40,      64'h0,       bsa_pkg::STATUS_BAD_ADDR);
        add_cfg(bsa_pkg::REG_BASE_ADDRESS, ~64'h0);
        add_chk(bsa_pkg::CMD_FREE,  64'h0,       64'h0,       bsa_pkg::STATUS_BAD_ADDR);
        add_chk(bsa_pkg::CMD_ALLOC, 64'h0,       64'h0,       bsa_pkg::STATUS_OK);
        add_chk(bsa_pkg::CMD_ALLOC, 64'h0,       64'h0,       bsa_pkg::STATUS_FULL);
        add_chk(bsa_pkg::CMD_FREE,  ~64'h0,      64'h0,       bsa_pkg::STATUS_OK);
        // upper data bits are dropped, shift becomes 31
        add_cfg(bsa_pkg::REG_SLOT_SHIFT, ~64'h0);
        add_cfg(bsa_pkg::REG_BASE_ADDRESS, 64'h0);
        add_chk(bsa_pkg::CMD_FREE,  64'h2_8000_0007, 64'h0,   bsa_pkg::STATUS_OK);
        add_chk(bsa_pkg::CMD_ALLOC, 64'h0,       64'h0,       bsa_pkg::STATUS_OK);
        add_chk(bsa_pkg::CMD_ALLOC, 64'h0,       64'h2_8000_0000, bsa_pkg::STATUS_OK);
        add_chk(bsa_pkg::CMD_FREE,  64'h20_0000_0000, 64'h0,  bsa_pkg::STATUS_BAD_ADDR);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_idle();
                cfg_write(dir_rows[i].reg_idx, dir_rows[i].value);
            end else begin
                r.command      = dir_rows[i].cmd;
                r.free_address = dir_rows[i].value;
                repeat (dir_rows[i].reps) send_req(r, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (ph = 0; ph < 10; ph++) begin
            wait_idle();
            idle_on = (ph != 5);
            case (ph % 4)
                0:       data = 64'h0;
                1:       data = rand64();
                2:       data = ~64'h0 - (64'($urandom_range(0, 3)) << 20);
                default: data = {32'h0, $urandom};
            endcase
            cfg_write(bsa_pkg::REG_BASE_ADDRESS, data);
            case (ph)
                0:       data = 64'd4;
                1:       data = 64'd24;
                2:       data = 64'd0;
                3:       data = 64'd31;
                default: data = 64'($urandom_range(0, 31));
            endcase
            if ($urandom_range(1))
                data[ADDR_W-1:SHIFT_W] = (ADDR_W-SHIFT_W)'(rand64());
            cfg_write(bsa_pkg::REG_SLOT_SHIFT, data);

            alloc_pct = $urandom_range(35, 75);
            mask = (64'h1 << slot_log2) - 64'h1;
            for (n = 0; n < 185; n++) begin
                r.free_address = rand64();
                if ($urandom_range(99) < alloc_pct) begin
                    r.command = bsa_pkg::CMD_ALLOC;
                end else begin
                    r.command = bsa_pkg::CMD_FREE;
                    pick = $urandom_range(99);
                    if (pick < 75) begin
                        addr = region_base
                             + (64'($urandom_range(0, NUM_SLOTS - 1)) << slot_log2)
                             + (rand64() & mask);
                        r.free_address = addr;
                    end else if (pick < 87) begin
                        r.free_address = rand64();
                    end else if (pick < 94) begin
                        r.free_address = region_base - 64'h1 - 64'($urandom_range(0, 255));
                    end else begin
                        r.free_address = region_base + (64'(NUM_SLOTS) << slot_log2)
                                       + 64'($urandom_range(0, 255));
                    end
                end
                send_req(r, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (80) @(posedge aclk);
        if (fail_count == 0 && expected_rsp_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #15000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
